/* design/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants for the image-plane LZ decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int LW_W     = 11;   // line_width register
    localparam int OL_W     = 27;   // out_length register, bytes_written
    localparam int CC_W     = 11;   // copy count
    localparam int CFG_IX_W = 1;
    localparam int CFG_D_W  = 27;
    localparam int DCALC_W  = 17;   // signed scratch width for the distance table

    localparam logic [CFG_IX_W-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_OUT_LENGTH = 1'b1;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_DONE  = 3'd1;
    localparam logic [2:0] ST_TRUNC = 3'd2;
    localparam logic [2:0] ST_OVFL  = 3'd3;
    localparam logic [2:0] ST_BADD  = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
        logic       in_last;
    } t_item;

endpackage

/* design/lzd_front.sv */
// ----------------------------------------------------------------------------
// lzd_front
// Input queue: takes words, looks up the copy distance from the line width.
// ----------------------------------------------------------------------------
module lzd_front #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int HISTORY_DEPTH  = 4096,
    parameter int DW             = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  lzd_pkg::t_item          i_item,
    input  logic [lzd_pkg::LW_W-1:0] i_line_width,
    output logic                    o_valid,
    output lzd_pkg::t_item          o_item,
    output logic [DW-1:0]           o_dist,
    input  logic                    i_pop
);
    import lzd_pkg::*;

    function automatic logic signed [DCALC_W-1:0] table_dist(
        input logic [3:0] sel, input logic [LW_W-1:0] w);
        logic signed [DCALC_W-1:0] ws;
        logic signed [DCALC_W-1:0] d;
        ws = $signed(DCALC_W'(w));
        unique case (sel)
            4'd1:    d = DCALC_W'(1);
            4'd2:    d = ws;
            4'd3:    d = ws + DCALC_W'(1);
            4'd4:    d = DCALC_W'(2);
            4'd5:    d = ws - DCALC_W'(1);
            4'd6:    d = ws <<< 1;
            4'd7:    d = DCALC_W'(3);
            4'd8:    d = (ws <<< 1) + DCALC_W'(2);
            4'd9:    d = ws + DCALC_W'(2);
            4'd10:   d = (ws <<< 1) + DCALC_W'(1);
            4'd11:   d = (ws <<< 1) - DCALC_W'(1);
            4'd12:   d = (ws <<< 1) - DCALC_W'(2);
            4'd13:   d = ws - DCALC_W'(2);
            4'd14:   d = (ws <<< 1) + ws;
            4'd15:   d = DCALC_W'(4);
            default: d = '0;
        endcase
        return d;
    endfunction

    logic [LW_W-1:0]            w;
    logic signed [DCALC_W-1:0]  d_raw;
    logic [DW-1:0]              d_ok;

    t_item                      r_ent [2];
    logic [DW-1:0]              r_ent_dist [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_cnt;
    logic                       push;

    always_comb begin
        if (DCALC_W'(i_line_width) > DCALC_W'(MAX_LINE_WIDTH)) w = LW_W'(MAX_LINE_WIDTH);
        else w = i_line_width;
        d_raw = table_dist(i_item.in_byte[7:4], w);
        // out-of-range distances are stored as zero and rejected later
        if (d_raw < $signed(DCALC_W'(1)) || d_raw > $signed(DCALC_W'(HISTORY_DEPTH)))
            d_ok = '0;
        else
            d_ok = DW'(d_raw);
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_ent[r_rp];
    assign o_dist     = r_ent_dist[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp]      <= i_item;
            r_ent_dist[r_wp] <= d_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

/* design/lzd_back.sv */
// ----------------------------------------------------------------------------
// lzd_back
// Decoder state, history memory and output register.
// ----------------------------------------------------------------------------
module lzd_back #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int DW            = $clog2(HISTORY_DEPTH + 1),
    parameter int AW            = $clog2(HISTORY_DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  lzd_pkg::t_item           i_item,
    input  logic [DW-1:0]            i_dist,
    output logic                     o_pop,
    input  logic [lzd_pkg::OL_W-1:0] i_out_length,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic                     o_out_valid,
    output logic [7:0]               o_out_byte,
    output logic [lzd_pkg::CC_W-1:0] o_copy_left,
    output logic                     o_frame_full,
    output logic [2:0]               o_status
);
    import lzd_pkg::*;

    localparam int SW = AW + 1;

    typedef enum logic [4:0] {
        M_FLAG       = 5'b00001,
        M_LITERAL    = 5'b00010,
        M_LENGTH     = 5'b00100,
        M_COPY       = 5'b01000,
        M_COPY_FINAL = 5'b10000
    } t_mode;

    logic [7:0]      mem [HISTORY_DEPTH];
    logic [7:0]      r_rdata;

    t_mode           r_mode, n_mode;
    logic [3:0]      r_ll, n_ll, ll_dec;
    logic [CC_W-1:0] r_cc, n_cc, n_sel;
    logic [DW-1:0]   r_dist, n_dist, st_dist;
    logic [2:0]      r_lh, n_lh;
    logic [OL_W-1:0] r_bw, n_bw, bw_inc;
    logic [AW-1:0]   r_ptr, n_ptr, ptr_inc, src;
    logic [2:0]      r_err, n_err;

    logic            r_b_valid, r_b_emit, r_b_mem, r_b_hit, r_b_full;
    logic [7:0]      r_b_byte, r_b_fwd;
    logic [AW-1:0]   r_b_waddr;
    logic [CC_W-1:0] r_b_cc;
    logic [2:0]      r_b_status;

    logic            adv, full_now, full_inc, copying, over, do_start, emit, emit_mem, hit;
    logic [SW-1:0]   pe, de;
    logic [7:0]      b;

    assign b   = i_item.in_byte;
    assign adv = i_valid && (!r_b_valid || i_res_ready);
    assign o_pop = adv;

    always_comb begin
        full_now = r_bw >= i_out_length;
        bw_inc   = OL_W'(r_bw + 1'b1);
        full_inc = bw_inc >= i_out_length;
        copying  = (r_mode == M_COPY) || (r_mode == M_COPY_FINAL);
        ptr_inc  = (r_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : AW'(r_ptr + 1'b1);
        ll_dec   = (r_ll != 4'd0) ? r_ll - 4'd1 : r_ll;

        pe  = {1'b0, r_ptr};
        de  = SW'(r_dist);
        src = (pe >= de) ? AW'(pe - de) : AW'(pe + SW'(HISTORY_DEPTH) - de);

        if (r_mode == M_LENGTH)        n_sel = {r_lh, b};
        else if (b[7:4] == 4'd0)       n_sel = {7'd0, b[3:0]};
        else                           n_sel = {8'd0, b[2:0]};
        over    = ((OL_W + 1)'(r_bw) + (OL_W + 1)'(n_sel)) > {1'b0, i_out_length};
        st_dist = (r_mode == M_LENGTH) ? r_dist : i_dist;

        n_mode = r_mode;  n_ll = r_ll;  n_cc = r_cc;  n_dist = r_dist;
        n_lh = r_lh;  n_bw = r_bw;  n_ptr = r_ptr;  n_err = r_err;
        emit = 1'b0;  emit_mem = 1'b0;  do_start = 1'b0;

        if (adv && r_err == ST_RUN) begin
            if (r_mode == M_FLAG && full_now) begin
                n_err = ST_DONE;
            end else if (i_item.action) begin
                if (copying && r_cc != '0) begin
                    if (full_now) begin
                        n_err = ST_OVFL;
                    end else begin
                        emit = 1'b1;  emit_mem = 1'b1;
                        n_ptr = ptr_inc;  n_bw = bw_inc;
                        n_cc = r_cc - 1'b1;
                        if (r_cc == CC_W'(1)) begin
                            if (full_inc) n_err = ST_DONE;
                            else if (r_mode == M_COPY_FINAL) n_err = ST_TRUNC;
                            n_mode = M_FLAG;
                        end
                    end
                end
            end else if (!copying) begin
                unique case (r_mode)
                    M_LITERAL: begin
                        if (full_now) begin
                            n_err = ST_OVFL;
                        end else begin
                            emit = 1'b1;
                            n_ptr = ptr_inc;  n_bw = bw_inc;  n_ll = ll_dec;
                            if (ll_dec == 4'd0) n_mode = M_FLAG;
                            if (ll_dec == 4'd0 && full_inc) n_err = ST_DONE;
                            else if (i_item.in_last) n_err = ST_TRUNC;
                        end
                    end
                    M_LENGTH: do_start = 1'b1;
                    default: begin
                        if (b[7:4] == 4'd0) begin
                            if (b[3:0] != 4'd0 && !i_item.in_last) begin
                                if (over) n_err = ST_OVFL;
                                else begin
                                    n_ll = b[3:0];
                                    n_mode = M_LITERAL;
                                end
                            end else if (i_item.in_last) begin
                                n_err = ST_TRUNC;
                            end
                        end else begin
                            n_dist = i_dist;
                            if (b[3]) begin
                                if (i_item.in_last) n_err = ST_TRUNC;
                                else begin
                                    n_lh = b[2:0];
                                    n_mode = M_LENGTH;
                                end
                            end else begin
                                do_start = 1'b1;
                            end
                        end
                    end
                endcase
                if (do_start) begin
                    if (n_sel == '0) begin
                        n_mode = M_FLAG;
                        if (full_now) n_err = ST_DONE;
                        else if (i_item.in_last) n_err = ST_TRUNC;
                    end else if (over) begin
                        n_err = ST_OVFL;
                    end else if (st_dist == '0 || OL_W'(st_dist) > r_bw) begin
                        n_err = ST_BADD;
                    end else begin
                        n_cc = n_sel;
                        n_mode = i_item.in_last ? M_COPY_FINAL : M_COPY;
                    end
                end
            end
        end

        // the output stage writes its byte this cycle; forward it on a match
        hit = emit_mem && r_b_valid && r_b_emit && (src == r_b_waddr);
    end

    assign o_res_valid  = r_b_valid;
    assign o_out_valid  = r_b_emit;
    assign o_out_byte   = r_b_mem ? (r_b_hit ? r_b_fwd : r_rdata) : r_b_byte;
    assign o_copy_left  = r_b_cc;
    assign o_frame_full = r_b_full;
    assign o_status     = r_b_status;

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_emit) mem[r_b_waddr] <= o_out_byte;
        if (adv) r_rdata <= mem[src];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_mem    <= emit_mem;
            r_b_byte   <= (emit && !emit_mem) ? b : 8'd0;
            r_b_hit    <= hit;
            r_b_fwd    <= o_out_byte;
            r_b_waddr  <= r_ptr;
            r_b_cc     <= n_cc;
            r_b_full   <= emit ? full_inc : full_now;
            r_b_status <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_FLAG;
            r_ll      <= '0;
            r_cc      <= '0;
            r_dist    <= '0;
            r_lh      <= '0;
            r_bw      <= '0;
            r_ptr     <= '0;
            r_err     <= ST_RUN;
            r_b_valid <= 1'b0;
            r_b_emit  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_ll   <= n_ll;
            r_cc   <= n_cc;
            r_dist <= n_dist;
            r_lh   <= n_lh;
            r_bw   <= n_bw;
            r_ptr  <= n_ptr;
            r_err  <= n_err;
            if (adv) begin
                r_b_valid <= 1'b1;
                r_b_emit  <= emit;
            end else if (i_res_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_RUN) |=> $stable(r_err))
        else $error("error code changed after halt");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit) |=> (r_bw == OL_W'($past(r_bw) + 1'b1)))
        else $error("bytes_written did not follow emitted byte");
    a_copy_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cc != '0) |-> (r_mode == M_COPY || r_mode == M_COPY_FINAL))
        else $error("copy pending outside copy mode");
    a_hit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_b_hit) |-> (r_b_mem && r_b_emit))
        else $error("forwarded byte on a non-copy result");
`endif

endmodule

/* design/lz_image_plane_decompressor_core.sv */
// ----------------------------------------------------------------------------
// lz_image_plane_decompressor_core
// Streaming LZ decoder with line-width based copy distances.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) carries one word per item: a
// compressed byte (i_action 0) or a copy tick (i_action 1). Every word taken
// gives exactly one result word on the output channel (o_res_valid/
// i_res_ready), in order.
// A taken word passes through its queue entry and then the result register
// before its result is presented on the output channel.
// Throughput: one word per cycle while the receiver takes results, set by the
// history memory doing one read and one write each cycle, with the output
// stage's byte forwarded to a copy that reads it back at once.
// When the receiver stalls, the result register holds and the two-entry
// input queue fills; o_in_ready then drops until a result is taken.
// Reset (i_rst_n low, synchronous) returns the parser to expecting a flag,
// clears counters and status, and sets line_width 1024, out_length 4096.
// History contents are not cleared; no unwritten byte is ever output.
// Configuration writes (i_cfg_we) take effect at once and belong to idle time.
// Once status is nonzero, words are still taken and answered but ignored.
// ----------------------------------------------------------------------------
module lz_image_plane_decompressor_core #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int HISTORY_DEPTH  = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lzd_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [lzd_pkg::CFG_D_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_in_last,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic [lzd_pkg::CC_W-1:0]    o_copy_left,
    output logic                        o_frame_full,
    output logic [2:0]                  o_status
);
    import lzd_pkg::*;

    localparam int DW = $clog2(HISTORY_DEPTH + 1);

    logic [LW_W-1:0] r_line_width;
    logic [OL_W-1:0] r_out_length;
    t_item           in_item, q_item;
    logic            q_valid, q_pop;
    logic [DW-1:0]   q_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_W'(1024);
            r_out_length <= OL_W'(4096);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LINE_WIDTH) r_line_width <= i_cfg_data[LW_W-1:0];
            else if (i_cfg_index == CFG_OUT_LENGTH) r_out_length <= i_cfg_data[OL_W-1:0];
        end
    end

    assign in_item = '{action: i_action, in_byte: i_in_byte, in_last: i_in_last};

    lzd_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .DW             (DW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .i_line_width (r_line_width),
        .o_valid      (q_valid),
        .o_item       (q_item),
        .o_dist       (q_dist),
        .i_pop        (q_pop)
    );

    lzd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .DW            (DW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .i_dist       (q_dist),
        .o_pop        (q_pop),
        .i_out_length (r_out_length),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_copy_left  (o_copy_left),
        .o_frame_full (o_frame_full),
        .o_status     (o_status)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image-plane LZ decoder. A scoreboard class
// predicts the result word for every accepted input word and checks the
// output channel in order. Stimulus: zero-length and boundary cases, then
// well-formed literal runs and copies with random content over several
// line widths and handshake pressure levels, then one randomly chosen
// frame-ending condition followed by words that must be ignored.
// ----------------------------------------------------------------------------
import lzd_pkg::*;

localparam int LZ_MAX_LINE   = 1024;
localparam int LZ_HIST_DEPTH = 4096;

typedef enum logic [2:0] {
    PM_FLAG,
    PM_LITERAL,
    PM_LENGTH,
    PM_COPY,
    PM_COPY_LAST
} t_parse_mode;

typedef struct {
    bit          out_valid;
    bit [7:0]    out_byte;
    bit [CC_W-1:0] copy_left;
    bit          frame_full;
    bit [2:0]    status;
} t_decoded;

class lz_scoreboard;
    bit [LW_W-1:0] line_width = 11'd1024;
    bit [OL_W-1:0] out_length = 27'd4096;
    t_parse_mode   mode = PM_FLAG;
    int            literal_left = 0;
    int            copy_count = 0;
    int            copy_dist = 0;
    bit [2:0]      len_high = 3'd0;
    bit [OL_W-1:0] bytes_written = '0;
    bit [7:0]      hist [LZ_HIST_DEPTH];
    int            hptr = 0;
    bit [2:0]      status = ST_RUN;
    t_decoded      pending[$];
    int            errors = 0;

    function void write_reg(bit [CFG_IX_W-1:0] idx, bit [CFG_D_W-1:0] val);
        if (idx == CFG_LINE_WIDTH) line_width = val[LW_W-1:0];
        else out_length = val[OL_W-1:0];
    endfunction

    function bit full();
        return bytes_written >= out_length;
    endfunction

    // distance picked by the high nibble of a copy flag
    function int span(int sel);
        int w;
        w = (line_width > LZ_MAX_LINE) ? LZ_MAX_LINE : int'(line_width);
        case (sel)
            1:  return 1;
            2:  return w;
            3:  return w + 1;
            4:  return 2;
            5:  return w - 1;
            6:  return w * 2;
            7:  return 3;
            8:  return (w + 1) * 2;
            9:  return w + 2;
            10: return w * 2 + 1;
            11: return w * 2 - 1;
            12: return (w - 1) * 2;
            13: return w - 2;
            14: return w * 3;
            15: return 4;
            default: return 0;
        endcase
    endfunction

    function void put(bit [7:0] b);
        hist[hptr] = b;
        hptr = (hptr + 1) % LZ_HIST_DEPTH;
        bytes_written = bytes_written + 1'b1;
    endfunction

    function void begin_copy(int n, bit last);
        if (n == 0) begin
            mode = PM_FLAG;
            if (full()) status = ST_DONE;
            else if (last) status = ST_TRUNC;
            return;
        end
        if (longint'(bytes_written) + n > longint'(out_length)) begin
            status = ST_OVFL;
            return;
        end
        if (copy_dist == 0 || copy_dist > int'(bytes_written) || copy_dist > LZ_HIST_DEPTH)
        begin
            status = ST_BADD;
            return;
        end
        copy_count = n;
        mode = last ? PM_COPY_LAST : PM_COPY;
    endfunction

    function void note_word(bit act, bit [7:0] b, bit last);
        t_decoded r;
        bit copying;
        int d;
        int n;
        r = '{default: 0};
        if (status == ST_RUN && mode == PM_FLAG && full()) status = ST_DONE;
        if (status == ST_RUN) begin
            copying = (mode == PM_COPY || mode == PM_COPY_LAST);
            if (act) begin
                if (copying && copy_count > 0) begin
                    if (full()) begin
                        status = ST_OVFL;
                    end else begin
                        r.out_byte = hist[(hptr + LZ_HIST_DEPTH - copy_dist) % LZ_HIST_DEPTH];
                        r.out_valid = 1'b1;
                        put(r.out_byte);
                        copy_count--;
                        if (copy_count == 0) begin
                            if (full()) status = ST_DONE;
                            else if (mode == PM_COPY_LAST) status = ST_TRUNC;
                            mode = PM_FLAG;
                        end
                    end
                end
            end else if (!copying) begin
                if (mode == PM_LITERAL) begin
                    if (full()) begin
                        status = ST_OVFL;
                    end else begin
                        r.out_byte = b;
                        r.out_valid = 1'b1;
                        put(b);
                        if (literal_left > 0) literal_left--;
                        if (literal_left == 0) mode = PM_FLAG;
                        if (literal_left == 0 && full()) status = ST_DONE;
                        else if (last) status = ST_TRUNC;
                    end
                end else if (mode == PM_LENGTH) begin
                    begin_copy({len_high, b}, last);
                end else if (b[7:4] == 4'h0) begin
                    n = b[3:0];
                    if (n > 0 && !last) begin
                        if (longint'(bytes_written) + n > longint'(out_length)) begin
                            status = ST_OVFL;
                        end else begin
                            literal_left = n;
                            mode = PM_LITERAL;
                        end
                    end else if (last) begin
                        status = ST_TRUNC;
                    end
                end else begin
                    d = span(b[7:4]);
                    copy_dist = (d < 1 || d > LZ_HIST_DEPTH) ? 0 : d;
                    if (b[3]) begin
                        if (last) begin
                            status = ST_TRUNC;
                        end else begin
                            len_high = b[2:0];
                            mode = PM_LENGTH;
                        end
                    end else begin
                        begin_copy(b[2:0], last);
                    end
                end
            end
        end
        r.copy_left = copy_count[CC_W-1:0];
        r.frame_full = full();
        r.status = status;
        pending.push_back(r);
    endfunction

    function void cmp(string name, int e, int a);
        if (e != a) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endfunction

    function void check_word(t_decoded got);
        t_decoded want;
        if (pending.size() == 0) begin
            $display("%0t result word with nothing pending: byte %0h status %0d",
                     $time, got.out_byte, got.status);
            errors++;
            return;
        end
        want = pending.pop_front();
        cmp("out_valid", want.out_valid, got.out_valid);
        cmp("out_byte", want.out_byte, got.out_byte);
        cmp("copy_left", want.copy_left, got.copy_left);
        cmp("frame_full", want.frame_full, got.frame_full);
        cmp("status", want.status, got.status);
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam bit [CFG_D_W-1:0] OL_MAX = 27'h4000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IX_W-1:0] i_cfg_index = '0;
    logic [CFG_D_W-1:0]  i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_action = 1'b0;
    logic [7:0]          i_in_byte = '0;
    logic                i_in_last = 1'b0;
    logic                o_res_valid;
    logic                i_res_ready = 1'b0;
    logic                o_out_valid;
    logic [7:0]          o_out_byte;
    logic [CC_W-1:0]     o_copy_left;
    logic                o_frame_full;
    logic [2:0]          o_status;

    lz_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_words = 0;
    int cycle_count = 0;

    lz_image_plane_decompressor_core #(
        .MAX_LINE_WIDTH(LZ_MAX_LINE),
        .HISTORY_DEPTH (LZ_HIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_copy_left (o_copy_left),
        .o_frame_full(o_frame_full),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // receiver side: random stall, check every taken result word
    always @(posedge i_clk) begin
        t_decoded got;
        if (o_res_valid && i_res_ready) begin
            got.out_valid = o_out_valid;
            got.out_byte = o_out_byte;
            got.copy_left = o_copy_left;
            got.frame_full = o_frame_full;
            got.status = o_status;
            sb.check_word(got);
        end
        i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(bit act, bit [7:0] b, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_word(act, b, last);
        sent_words++;
    endtask

    task automatic write_reg(bit [CFG_IX_W-1:0] idx, bit [CFG_D_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, wait for every pending result word, then idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ticks until the copy is done; stray bytes in between must be ignored
    task automatic drain_copy();
        while (sb.copy_count != 0 && sb.status == ST_RUN) begin
            if ($urandom_range(9) == 0) send_word(1'b0, 8'($urandom), 1'($urandom));
            send_word(1'b1, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_unit();
        int pick;
        int n;
        int hi;
        int sel;
        int s;
        int d;
        int cands[$];
        pick = $urandom_range(99);
        for (s = 1; s < 16; s++) begin
            d = sb.span(s);
            if (d >= 1 && d <= int'(sb.bytes_written) && d <= LZ_HIST_DEPTH)
                cands.push_back(s);
        end
        if (pick >= 88) begin
            // tick with no copy pending
            send_word(1'b1, 8'($urandom), 1'($urandom));
        end else if (pick >= 50 && cands.size() > 0) begin
            sel = cands[$urandom_range(cands.size() - 1)];
            if ($urandom_range(9) < 7) begin
                n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
                send_word(1'b0, {4'(sel), 1'b0, 3'(n)}, 1'b0);
            end else begin
                // extended length, mostly short
                hi = ($urandom_range(29) == 0) ? $urandom_range(1, 7) : 0;
                send_word(1'b0, {4'(sel), 1'b1, 3'(hi)}, 1'b0);
                send_word(1'b0, ($urandom_range(7) == 0) ? 8'($urandom) :
                          8'($urandom_range(31)), 1'b0);
            end
            drain_copy();
        end else begin
            n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 15);
            send_word(1'b0, {4'h0, 4'(n)}, 1'b0);
            repeat (n) begin
                if ($urandom_range(15) == 0) send_word(1'b1, 8'($urandom), 1'($urandom));
                send_word(1'b0, 8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        int ph;
        int target;
        int ending;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length cases on a one-byte frame
        write_reg(CFG_OUT_LENGTH, 27'd1);
        send_word(1'b1, 8'h00, 1'b0);
        send_word(1'b0, 8'h00, 1'b0);
        send_word(1'b0, 8'h10, 1'b0);
        send_word(1'b0, 8'h18, 1'b0);
        send_word(1'b0, 8'h00, 1'b0);
        settle();

        write_reg(CFG_OUT_LENGTH, OL_MAX);
        write_reg(CFG_LINE_WIDTH, 27'd1024);
        send_word(1'b0, 8'h04, 1'b0);
        send_word(1'b0, 8'h00, 1'b0);
        send_word(1'b0, 8'hFF, 1'b0);
        send_word(1'b0, 8'h55, 1'b0);
        send_word(1'b0, 8'hAA, 1'b0);
        send_word(1'b1, 8'hFF, 1'b1);
        send_word(1'b0, 8'h13, 1'b0);
        send_word(1'b0, 8'hC3, 1'b1);   // byte during a copy: ignored
        drain_copy();
        send_word(1'b0, 8'hF8, 1'b0);   // distance 4, extended length 5
        send_word(1'b0, 8'h05, 1'b0);
        drain_copy();

        for (ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_LINE_WIDTH, 27'd1024);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_reg(CFG_LINE_WIDTH, 27'd3);
                    send_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_reg(CFG_LINE_WIDTH, 27'd2047);   // clamps to the max width
                    send_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    write_reg(CFG_LINE_WIDTH, 27'($urandom_range(3, 1024)));
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (ph > 0) write_reg(CFG_OUT_LENGTH, 27'($urandom_range(1 << 20, 1 << 26)));
            target = sent_words + 80;
            while (sent_words < target) random_unit();
        end

        // close the frame one way or another; everything after is ignored
        settle();
        ending = $urandom_range(6);
        case (ending)
            0: begin
                write_reg(CFG_OUT_LENGTH, 27'(sb.bytes_written + 3));
                send_word(1'b0, 8'h03, 1'b0);
                repeat (3) send_word(1'b0, 8'($urandom), 1'b0);
            end
            1: begin
                write_reg(CFG_OUT_LENGTH, 27'(sb.bytes_written + 2));
                send_word(1'b0, 8'h12, 1'b0);
                drain_copy();
            end
            2: begin
                send_word(1'b0, 8'h02, 1'b0);
                send_word(1'b0, 8'($urandom), 1'b1);
            end
            3: begin
                // last byte starts a copy: drained, then truncated
                send_word(1'b0, 8'h13, 1'b1);
                drain_copy();
            end
            4: begin
                write_reg(CFG_OUT_LENGTH, 27'(sb.bytes_written + 1));
                send_word(1'b0, 8'h05, 1'b0);
            end
            5: begin
                // frame length dropped under a running copy
                send_word(1'b0, 8'h14, 1'b0);
                send_word(1'b1, 8'($urandom), 1'b0);
                settle();
                write_reg(CFG_OUT_LENGTH, 27'(sb.bytes_written));
                send_word(1'b1, 8'($urandom), 1'b0);
            end
            default: begin
                if (sb.bytes_written < 3072 && $urandom_range(1) == 1) begin
                    write_reg(CFG_LINE_WIDTH, 27'd1024);
                    send_word(1'b0, 8'hE1, 1'b0);   // distance past written data
                end else begin
                    write_reg(CFG_LINE_WIDTH, 27'd2);
                    send_word(1'b0, 8'hD1, 1'b0);   // distance of zero
                end
            end
        endcase
        repeat (16) send_word(1'($urandom), 8'($urandom), 1'($urandom));

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[lz_image_plane_decompressor_core] OK");
        end else begin
            $display("[lz_image_plane_decompressor_core] ERROR");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t timeout, %0d result words pending", $time, sb.pending.size());
        $display("[lz_image_plane_decompressor_core] ERROR");
        $finish;
    end

endmodule

/* files.f */
design/lzd_pkg.sv
design/lzd_front.sv
design/lzd_back.sv
design/lz_image_plane_decompressor_core.sv
tb/tb_top.sv
